// ----- hdl/wav_chunk_stream_parser_assert.svh -----
// Assertion macros for the WAV chunk stream parser.
`ifndef WAV_CHUNK_STREAM_PARSER_ASSERT_SVH
`define WAV_CHUNK_STREAM_PARSER_ASSERT_SVH

// Condition holds at every edge out of reset.
`define WCSP_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence holds in the same cycle as the antecedent.
`define WCSP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define WCSP_ASSERT_THEN(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/wcsp_pkg.sv -----
// Shared types and constants of the WAV chunk stream parser.
package wcsp_pkg;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [2:0] STATUS_OK         = 3'd0;
  localparam logic [2:0] STATUS_TOO_SHORT  = 3'd1;
  localparam logic [2:0] STATUS_BAD_HEADER = 3'd2;
  localparam logic [2:0] STATUS_NO_FMT     = 3'd3;
  localparam logic [2:0] STATUS_NO_DATA    = 3'd4;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  pcm_byte;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] bits_per_sample;
    logic [2:0]  status;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic    first_valid;
    logic    second_valid;
    result_t first;
    result_t second;
  } push_t;

  typedef struct packed {
    logic                 has_room;
    logic                 not_empty;
    logic [OUT_CNT_W-1:0] level;
  } queue_status_t;

endpackage

// ----- hdl/wcsp_stream_if.sv -----
// Handshake channels for file bytes in and parser results out.
interface wcsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface wcsp_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  pcm_byte;
  logic [31:0] sample_rate;
  logic [15:0] channel_count;
  logic [15:0] bits_per_sample;
  logic [2:0]  status;
  logic        last_of_run;

  modport source (output valid, output result_kind, output pcm_byte, output sample_rate,
                  output channel_count, output bits_per_sample, output status,
                  output last_of_run, input ready);
  modport sink (input valid, input result_kind, input pcm_byte, input sample_rate,
                input channel_count, input bits_per_sample, input status,
                input last_of_run, output ready);
endinterface

// ----- hdl/wcsp_parser.sv -----
// Chunk walker: parse state per accepted byte and the results it raises.
module wcsp_parser import wcsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] file_byte,
  input  logic       end_of_file,
  output push_t      push
);

  typedef enum logic [5:0] {
    PH_RIFF = 6'b000001,
    PH_CHDR = 6'b000010,
    PH_FMT  = 6'b000100,
    PH_DATA = 6'b001000,
    PH_SKIP = 6'b010000,
    PH_HALT = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [15:0] bits_per_sample;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
  } format_t;

  typedef struct packed {
    logic bad_header;
    logic fmt_found;
    logic data_found;
  } flags_t;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [5:0]  MIN_FILE_LEN = 6'd44;

  logic [5:0]  pos, pos_next;
  phase_t      phase, phase_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [32:0] bytes_left, bytes_left_next;
  logic [4:0]  body_offset, body_offset_next;
  format_t     pending, pending_next;
  format_t     committed, committed_next;
  flags_t      flags, flags_next;

  logic [31:0] tag_in;
  logic [31:0] full_len;
  logic        emit;
  logic [2:0]  status;
  result_t     data_res;
  result_t     report_res;

  always_comb begin
    pos_next          = (pos == MIN_FILE_LEN) ? pos : pos + 6'd1;
    phase_next        = phase;
    tag_shift_next    = tag_shift;
    chunk_length_next = chunk_length;
    bytes_left_next   = bytes_left;
    body_offset_next  = body_offset;
    pending_next      = pending;
    committed_next    = committed;
    flags_next        = flags;
    emit              = 1'b0;
    tag_in            = {tag_shift[23:0], file_byte};
    full_len          = {file_byte, chunk_length[23:0]};

    case (phase)
      PH_RIFF: begin
        tag_shift_next = tag_in;
        if (pos == 6'd3 && tag_in != TAG_RIFF) begin
          flags_next.bad_header = 1'b1;
          phase_next            = PH_HALT;
        end else if (pos == 6'd11) begin
          if (tag_in != TAG_WAVE) begin
            flags_next.bad_header = 1'b1;
            phase_next            = PH_HALT;
          end else begin
            phase_next       = PH_CHDR;
            body_offset_next = 5'd0;
          end
        end
      end
      PH_CHDR: begin
        if (body_offset < 5'd4) begin
          tag_shift_next = tag_in;
        end else begin
          case (body_offset[1:0])
            2'd0:    chunk_length_next[7:0]   = file_byte;
            2'd1:    chunk_length_next[15:8]  = file_byte;
            2'd2:    chunk_length_next[23:16] = file_byte;
            default: chunk_length_next[31:24] = file_byte;
          endcase
        end
        body_offset_next = body_offset + 5'd1;
        if (body_offset == 5'd7) begin
          body_offset_next  = 5'd0;
          chunk_length_next = full_len;
          bytes_left_next   = {1'b0, full_len} + {32'd0, full_len[0]};
          if (full_len == 32'd0) begin
            phase_next = PH_CHDR;
          end else if (tag_shift == TAG_FMT && full_len >= 32'd16) begin
            pending_next = '0;
            phase_next   = PH_FMT;
          end else if (tag_shift == TAG_DATA) begin
            phase_next = PH_DATA;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_FMT, PH_DATA, PH_SKIP: begin
        if (phase == PH_FMT && body_offset < 5'd16) begin
          case (body_offset)
            5'd2:    pending_next.channel_count[7:0]    = file_byte;
            5'd3:    pending_next.channel_count[15:8]   = file_byte;
            5'd4:    pending_next.sample_rate[7:0]      = file_byte;
            5'd5:    pending_next.sample_rate[15:8]     = file_byte;
            5'd6:    pending_next.sample_rate[23:16]    = file_byte;
            5'd7:    pending_next.sample_rate[31:24]    = file_byte;
            5'd14:   pending_next.bits_per_sample[7:0]  = file_byte;
            5'd15:   pending_next.bits_per_sample[15:8] = file_byte;
            default: pending_next = pending;
          endcase
          body_offset_next = body_offset + 5'd1;
          if (body_offset == 5'd15) begin
            committed_next       = pending_next;
            flags_next.fmt_found = 1'b1;
          end
        end else if (phase == PH_DATA && !(chunk_length[0] && bytes_left == 33'd1)) begin
          emit                  = 1'b1;
          flags_next.data_found = 1'b1;
        end
        bytes_left_next = bytes_left - 33'd1;
        if (bytes_left == 33'd1) begin
          phase_next       = PH_CHDR;
          body_offset_next = 5'd0;
        end
      end
      PH_HALT: phase_next = PH_HALT;
      default: phase_next = PH_HALT;
    endcase

    if (pos_next < MIN_FILE_LEN) begin
      status = STATUS_TOO_SHORT;
    end else if (flags_next.bad_header) begin
      status = STATUS_BAD_HEADER;
    end else if (!flags_next.fmt_found) begin
      status = STATUS_NO_FMT;
    end else if (!flags_next.data_found) begin
      status = STATUS_NO_DATA;
    end else begin
      status = STATUS_OK;
    end

    data_res                 = '0;
    data_res.result_kind     = KIND_DATA;
    data_res.pcm_byte        = file_byte;
    data_res.status          = STATUS_OK;
    data_res.last_of_run     = !end_of_file;

    report_res                 = '0;
    report_res.result_kind     = KIND_REPORT;
    report_res.sample_rate     = committed_next.sample_rate;
    report_res.channel_count   = committed_next.channel_count;
    report_res.bits_per_sample = committed_next.bits_per_sample;
    report_res.status          = status;
    report_res.last_of_run     = 1'b1;

    push.first_valid  = accept && (emit || end_of_file);
    push.second_valid = accept && emit && end_of_file;
    push.first        = emit ? data_res : report_res;
    push.second       = report_res;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_file)) begin
      pos          <= '0;
      phase        <= PH_RIFF;
      tag_shift    <= '0;
      chunk_length <= '0;
      bytes_left   <= '0;
      body_offset  <= '0;
      pending      <= '0;
      committed    <= '0;
      flags        <= '0;
    end else if (accept) begin
      pos          <= pos_next;
      phase        <= phase_next;
      tag_shift    <= tag_shift_next;
      chunk_length <= chunk_length_next;
      bytes_left   <= bytes_left_next;
      body_offset  <= body_offset_next;
      pending      <= pending_next;
      committed    <= committed_next;
      flags        <= flags_next;
    end
  end

endmodule

// ----- hdl/wcsp_out_queue.sv -----
// Result queue: takes up to two results a cycle, hands one out per request.
module wcsp_out_queue import wcsp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  push_t         push,
  input  logic          sink_ready,
  output result_t       head,
  output queue_status_t status
);

  result_t              mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_CNT_W-1:0] count;
  logic [1:0]           n_push;
  logic                 pop;

  assign n_push = {1'b0, push.first_valid} + {1'b0, push.second_valid};
  assign pop    = (count != '0) && sink_ready;

  assign head             = mem[rd_ptr];
  assign status.not_empty = (count != '0);
  assign status.has_room  = (count <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign status.level     = count;

  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.second_valid) begin
      mem[wr_ptr + OUT_PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUT_PTR_W'(n_push);
      rd_ptr <= rd_ptr + OUT_PTR_W'(pop);
      count  <= count + OUT_CNT_W'(n_push) - OUT_CNT_W'(pop);
    end
  end

endmodule

// ----- hdl/wav_chunk_stream_parser.sv -----
// Top level of the WAV chunk stream parser.
// Usage:
//   byte_chan carries a WAV file one byte per request; end_of_file marks the
//   last byte. result_chan returns forwarded data chunk bytes (result_kind 0)
//   and one end-of-file report per file (result_kind 1) with the committed
//   fmt fields and a status; last_of_run flags the final result of a byte.
//   Each result is held in the result queue until result_chan takes it.
//   Throughput: one byte per cycle while byte_chan.ready is high. A byte that
//   both carries data and ends the file raises two results, which leave through
//   a four-entry result queue; byte_chan.ready drops while fewer than two are free.
//   Reset (rst, synchronous) empties the queue and returns the parser to the
//   RIFF tag; after every end-of-file byte the parser returns there too.
//   When result_chan stalls, results wait in the queue and byte_chan.ready
//   falls once the queue is nearly full; no result is dropped.
`include "wav_chunk_stream_parser_assert.svh"

module wav_chunk_stream_parser import wcsp_pkg::*; (
  input logic        clk,
  input logic        rst,
  wcsp_in_if.sink    byte_chan,
  wcsp_out_if.source result_chan
);

  localparam logic [OUT_CNT_W-1:0] LEVEL_MAX = OUT_CNT_W'(OUT_DEPTH);

  logic          byte_accept;
  push_t         push;
  result_t       head;
  queue_status_t q_status;

  assign byte_accept    = byte_chan.valid && byte_chan.ready;
  assign byte_chan.ready = q_status.has_room;

  wcsp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (byte_accept),
    .file_byte   (byte_chan.file_byte),
    .end_of_file (byte_chan.end_of_file),
    .push        (push)
  );

  wcsp_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .sink_ready (result_chan.ready),
    .head       (head),
    .status     (q_status)
  );

  assign result_chan.valid           = q_status.not_empty;
  assign result_chan.result_kind     = head.result_kind;
  assign result_chan.pcm_byte        = head.pcm_byte;
  assign result_chan.sample_rate     = head.sample_rate;
  assign result_chan.channel_count   = head.channel_count;
  assign result_chan.bits_per_sample = head.bits_per_sample;
  assign result_chan.status          = head.status;
  assign result_chan.last_of_run     = head.last_of_run;

  `WCSP_ASSERT_HOLDS(a_level_bound, q_status.level <= LEVEL_MAX, "result queue overflow")
  `WCSP_ASSERT_THEN(a_report_queued, byte_accept && byte_chan.end_of_file, result_chan.valid, "end of file raised no report")
  `WCSP_ASSERT_SAME(a_report_last, result_chan.valid && result_chan.result_kind == KIND_REPORT, result_chan.last_of_run, "report not last of run")
  `WCSP_ASSERT_SAME(a_data_clean, result_chan.valid && result_chan.result_kind == KIND_DATA, result_chan.status == STATUS_OK && result_chan.sample_rate == 32'd0, "data result carries report fields")

endmodule
